// File: sv/orcd_pkg.sv
package orcd_pkg;

  localparam int unsigned MaxTagChars = 8;
  localparam int unsigned PrefixChars = 16;
  localparam int unsigned BitmapBytes = 4;
  localparam int unsigned LenSat      = 31;
  localparam int unsigned LenW        = 5;
  localparam int unsigned QueueDepth  = 2;

  typedef enum logic [3:0] {
    ST_DATA     = 4'd0,
    ST_NO_MATCH = 4'd1,
    ST_UNKNOWN  = 4'd2,
    ST_NO_DATA  = 4'd3,
    ST_UNABLE   = 4'd4,
    ST_STOPPED  = 4'd5,
    ST_CAN_ERR  = 4'd6,
    ST_BUS_ERR  = 4'd7,
    ST_BUF_FULL = 4'd8,
    ST_ADAPTER  = 4'd9,
    ST_DATA_ERR = 4'd10
  } status_e;

  localparam logic [0:0] CfgTagText   = 1'b0;
  localparam logic [0:0] CfgTagLength = 1'b1;

  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChPrompt = 8'h3e;
  localparam logic [7:0] ChSpace = 8'h20;

  // classified request between front and back
  typedef struct packed {
    logic       eol;
    logic       eor;
    logic [7:0] ch;
  } req_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c >= "0" && c <= "9") v = c - 8'h30;
    else if (c >= "a" && c <= "f") v = c - 8'h57;
    else v = c - 8'h37;
    return v[3:0];
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

endpackage

// File: sv/obd_reply_classifier_decoder_unit.sv
// Takes an adapter reply one character per request on s_axis, one per cycle unless stalled,
// and gives one result on m_axis for each request that marks end of reply. Spaces are
// dropped and CR, LF or '>' close a line. A two-entry queue parts the front classifier
// from the line decoder, which updates once per request; a result waits in an output
// register while further characters still flow in. Write tag_text and tag_length only idle.
module obd_reply_classifier_decoder_unit #(
  parameter int unsigned MaxTagChars = orcd_pkg::MaxTagChars,
  parameter int unsigned PrefixChars = orcd_pkg::PrefixChars,
  parameter int unsigned BitmapBytes = orcd_pkg::BitmapBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // char_code
  input  logic [0:0]  s_axis_tuser,   // char_valid
  input  logic        s_axis_tlast,   // end_of_reply
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // status, byte_found, byte_value, word_found,
                                      // word_value, bitmap_found, bitmap_value
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  logic [63:0]    tag_text_q;
  logic [3:0]     tag_length_q;
  logic           push, full, empty, pop;
  orcd_pkg::req_t wreq, rreq;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_text_q   <= '0;
      tag_length_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        orcd_pkg::CfgTagText:   tag_text_q   <= cfg_data_i;
        orcd_pkg::CfgTagLength: tag_length_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  orcd_front u_front (
    .valid_i(s_axis_tvalid), .ready_o(s_axis_tready),
    .ch_i(s_axis_tdata), .ch_valid_i(s_axis_tuser[0]), .eor_i(s_axis_tlast),
    .push_o(push), .req_o(wreq), .full_i(full)
  );

  orcd_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(wreq), .full_o(full),
    .empty_o(empty), .pop_i(pop), .data_o(rreq)
  );

  orcd_back #(
    .MaxTagChars(MaxTagChars), .PrefixChars(PrefixChars), .BitmapBytes(BitmapBytes)
  ) u_back (
    .clk_i, .rst_ni, .empty_i(empty), .req_i(rreq), .pop_o(pop),
    .tag_text_i(tag_text_q), .tag_length_i(tag_length_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_o(m_axis_tdata)
  );

endmodule

// File: sv/orcd_front.sv
module orcd_front (
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [7:0]           ch_i,
  input  logic                 ch_valid_i,
  input  logic                 eor_i,
  output logic                 push_o,
  output orcd_pkg::req_t       req_o,
  input  logic                 full_i
);

  logic is_end;
  logic is_space;

  assign ready_o  = !full_i;
  assign is_end   = ch_valid_i && (ch_i == orcd_pkg::ChCr || ch_i == orcd_pkg::ChLf ||
                                   ch_i == orcd_pkg::ChPrompt);
  assign is_space = ch_valid_i && ch_i == orcd_pkg::ChSpace;

  // bare markers and spaces without end of reply carry nothing
  assign push_o    = valid_i && !full_i && (eor_i || (ch_valid_i && !is_space));
  assign req_o.ch  = ch_i;
  assign req_o.eol = !ch_valid_i || is_end || is_space;
  assign req_o.eor = eor_i;

endmodule

// File: sv/orcd_queue.sv
module orcd_queue #(
  parameter int unsigned Depth = orcd_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  orcd_pkg::req_t data_i,
  output logic           full_o,
  output logic           empty_o,
  input  logic           pop_i,
  output orcd_pkg::req_t data_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  orcd_pkg::req_t       mem_q [Depth];
  logic [AW-1:0]        wp_q, rp_q;
  logic [AW:0]          cnt_q;

  assign full_o  = cnt_q == (AW+1)'(Depth);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (pop_i)  rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) full_o |-> !push_i)
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) empty_o |-> !pop_i)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(Depth)) else $error("queue count overflow");

endmodule

// File: sv/orcd_back.sv
module orcd_back #(
  parameter int unsigned MaxTagChars = orcd_pkg::MaxTagChars,
  parameter int unsigned PrefixChars = orcd_pkg::PrefixChars,
  parameter int unsigned BitmapBytes = orcd_pkg::BitmapBytes
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  orcd_pkg::req_t       req_i,
  output logic                 pop_o,
  input  logic [63:0]          tag_text_i,
  input  logic [3:0]           tag_length_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [63:0]          out_data_o
);

  localparam int unsigned LenW     = orcd_pkg::LenW;
  localparam int unsigned HexBytes = (BitmapBytes > 2) ? BitmapBytes : 2;

  logic [7:0]      pre_q [PrefixChars];
  logic [LenW-1:0] len_q, len_d;
  logic [2:0]      ep_q, ep_d;
  logic            es_q, es_d;
  logic [3:0]      dp_q, dp_d;
  logic            ds_q, ds_d;
  logic [3:0]      fts_q, fts_d;
  logic            any_q, any_d, tls_q, tls_d;
  logic [7:0]      fb_q, fb_d;
  logic            fbok_q, fbok_d;
  logic [15:0]     fw_q, fw_d;
  logic            fwok_q, fwok_d;
  logic [31:0]     bm_q, bm_d;
  logic            bmany_q, bmany_d;
  logic            ov_q;
  logic [63:0]     od_q;

  logic            go, is_char, ends_line;
  logic [7:0]      c;
  logic [7:0]      pre_n [PrefixChars];
  logic [LenW-1:0] len_n;
  logic [2:0]      ep_n;
  logic            es_n;
  logic [3:0]      dp_n;
  logic            ds_n;
  logic [LenW-1:0] kept;
  logic [3:0]      tl;
  logic [3:0]      st_line, st_rep;
  logic            tag_ok, bm_ok;
  logic [31:0]     bits;
  logic [7:0]      by [HexBytes];
  logic            byok [HexBytes];
  logic [7:0]      err_pat [5];
  logic [7:0]      derr_pat [9];

  assign err_pat  = '{"E", "R", "R", "O", "R"};
  assign derr_pat = '{"D", "A", "T", "A", "E", "R", "R", "O", "R"};

  assign go        = !empty_i && (!ov_q || out_ready_i || !req_i.eor);
  assign pop_o     = go;
  assign is_char   = !req_i.eol;
  assign ends_line = req_i.eol || req_i.eor;
  assign c         = req_i.ch;
  assign kept      = (32'(len_n) < PrefixChars) ? len_n : LenW'(PrefixChars);
  assign tl        = (tag_length_i > 4'(MaxTagChars)) ? 4'(MaxTagChars) : tag_length_i;

  function automatic logic sw(input logic [7:0] p [PrefixChars], input logic [LenW-1:0] k,
                              input logic [79:0] kw, input int unsigned n);
    logic r;
    r = k >= LenW'(n);
    for (int i = 0; i < 10; i++)
      if (i < n && p[i] != kw[8*(n-1-i) +: 8]) r = 1'b0;
    return r;
  endfunction

  // line state with this request's character taken in
  always_comb begin
    len_n = len_q; ep_n = ep_q; es_n = es_q; dp_n = dp_q; ds_n = ds_q;
    for (int i = 0; i < PrefixChars; i++)
      pre_n[i] = (is_char && 32'(len_q) == 32'(i)) ? c : pre_q[i];
    if (is_char) begin
      if (len_q < LenW'(orcd_pkg::LenSat)) len_n = len_q + 1'b1;
      if (!es_q) begin
        if (c == err_pat[ep_q]) begin
          if (ep_q == 3'd4) begin es_n = 1'b1; ep_n = '0; end
          else ep_n = ep_q + 1'b1;
        end else ep_n = (c == "E") ? 3'd1 : 3'd0;
      end
      if (!ds_q) begin
        if (c == derr_pat[dp_q]) begin
          if (dp_q == 4'd8) begin ds_n = 1'b1; dp_n = '0; end
          else dp_n = dp_q + 1'b1;
        end else dp_n = (c == "D") ? 4'd1 : 4'd0;
      end
    end
  end

  always_comb begin
    st_line = orcd_pkg::ST_DATA;
    if (len_n == LenW'(1) && pre_n[0] == "?") st_line = orcd_pkg::ST_UNKNOWN;
    else if (sw(pre_n, kept, 80'("NODATA"), 6)) st_line = orcd_pkg::ST_NO_DATA;
    else if (sw(pre_n, kept, 80'("UNABLE"), 6)) st_line = orcd_pkg::ST_UNABLE;
    else if (sw(pre_n, kept, 80'("STOPPED"), 7)) st_line = orcd_pkg::ST_STOPPED;
    else if (sw(pre_n, kept, 80'("CANERROR"), 8)) st_line = orcd_pkg::ST_CAN_ERR;
    else if (sw(pre_n, kept, 80'("BUSERROR"), 8)) st_line = orcd_pkg::ST_BUS_ERR;
    else if (sw(pre_n, kept, 80'("BUSINIT"), 7) && es_n) st_line = orcd_pkg::ST_BUS_ERR;
    else if (sw(pre_n, kept, 80'("BUFFERFULL"), 10)) st_line = orcd_pkg::ST_BUF_FULL;
    else if (len_n == LenW'(5) && sw(pre_n, kept, 80'("ERR"), 3) &&
             orcd_pkg::is_dig(pre_n[3]) && orcd_pkg::is_dig(pre_n[4]))
      st_line = orcd_pkg::ST_ADAPTER;
    else if (ds_n) st_line = orcd_pkg::ST_DATA_ERR;
  end

  always_comb begin
    tag_ok = kept >= LenW'(tl);
    for (int i = 0; i < MaxTagChars; i++)
      if (4'(i) < tl && pre_n[i] != tag_text_i[8*i +: 8]) tag_ok = 1'b0;
    for (int i = 0; i < HexBytes; i++) begin
      logic [LenW+1:0] pos;
      logic [7:0]      a, b;
      pos = (LenW+2)'(tl) + (LenW+2)'(2*i);
      a = 8'h00;
      b = 8'h00;
      for (int j = 0; j < PrefixChars; j++) begin
        if (pos == (LenW+2)'(j)) a = pre_n[j];
        if (pos + 1'b1 == (LenW+2)'(j)) b = pre_n[j];
      end
      byok[i] = (pos + 2'd2 <= (LenW+2)'(kept)) && orcd_pkg::is_hex(a) && orcd_pkg::is_hex(b);
      by[i]   = {orcd_pkg::hex_val(a), orcd_pkg::hex_val(b)};
    end
    bm_ok = 1'b1;
    bits  = '0;
    for (int i = 0; i < BitmapBytes; i++) begin
      bm_ok = bm_ok && byok[i];
      bits  = {bits[23:0], by[i]};
    end
  end

  always_comb begin
    len_d = len_n; ep_d = ep_n; es_d = es_n; dp_d = dp_n; ds_d = ds_n;
    fts_d = fts_q; any_d = any_q; tls_d = tls_q; fb_d = fb_q; fbok_d = fbok_q;
    fw_d = fw_q; fwok_d = fwok_q; bm_d = bm_q; bmany_d = bmany_q;
    if (ends_line) begin
      if (len_n != '0) begin
        any_d = 1'b1;
        if (fts_q == orcd_pkg::ST_DATA) fts_d = st_line;
        if (tag_ok) begin
          if (!tls_q) begin
            tls_d = 1'b1;
            if (byok[0]) begin
              fbok_d = 1'b1; fb_d = by[0];
              if (byok[1]) begin
                fwok_d = 1'b1; fw_d = {by[0], by[1]};
              end
            end
          end
          if (bm_ok) begin bm_d = bm_q | bits; bmany_d = 1'b1; end
        end
      end
      len_d = '0; ep_d = '0; es_d = 1'b0; dp_d = '0; ds_d = 1'b0;
    end
  end

  always_comb begin
    if (tl != '0 && tls_d) st_rep = orcd_pkg::ST_DATA;
    else if (fts_d != orcd_pkg::ST_DATA) st_rep = fts_d;
    else if (tl == '0 && any_d) st_rep = orcd_pkg::ST_DATA;
    else st_rep = orcd_pkg::ST_NO_MATCH;
  end

  always_ff @(posedge clk_i) begin
    if (go && is_char && 32'(len_q) < PrefixChars) pre_q[len_q[$clog2(PrefixChars)-1:0]] <= c;
    if (go && req_i.eor)
      od_q <= {1'b0, bmany_d ? bm_d : 32'h0, bmany_d, fwok_d ? fw_d : 16'h0, fwok_d,
               fbok_d ? fb_d : 8'h0, fbok_d, st_rep};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0; ep_q <= '0; es_q <= 1'b0; dp_q <= '0; ds_q <= 1'b0;
      fts_q <= '0; any_q <= 1'b0; tls_q <= 1'b0; fb_q <= '0; fbok_q <= 1'b0;
      fw_q <= '0; fwok_q <= 1'b0; bm_q <= '0; bmany_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      if (out_ready_i) ov_q <= 1'b0;
      if (go) begin
        if (req_i.eor) begin
          ov_q <= 1'b1;
          len_q <= '0; ep_q <= '0; es_q <= 1'b0; dp_q <= '0; ds_q <= 1'b0;
          fts_q <= '0; any_q <= 1'b0; tls_q <= 1'b0; fb_q <= '0; fbok_q <= 1'b0;
          fw_q <= '0; fwok_q <= 1'b0; bm_q <= '0; bmany_q <= 1'b0;
        end else begin
          len_q <= len_d; ep_q <= ep_d; es_q <= es_d; dp_q <= dp_d; ds_q <= ds_d;
          fts_q <= fts_d; any_q <= any_d; tls_q <= tls_d; fb_q <= fb_d; fbok_q <= fbok_d;
          fw_q <= fw_d; fwok_q <= fwok_d; bm_q <= bm_d; bmany_q <= bmany_d;
        end
      end
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i) |=> ov_q) else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i) |=> $stable(od_q)) else $error("result changed while held");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && req_i.eor) |=> (len_q == '0 && !tls_q && !bmany_q)) else $error("reply not cleared");

endmodule
